@@ src/cef_pkg.sv @@
// Shared types, constants and helper functions for the cartoon edge/quantize filter.
// Used by every module of the block but cef_ram; depends on nothing.
package cef_pkg;

    localparam int MaxWidth   = 2048;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int DimW       = 12;
    localparam int StoredRows = 4;
    localparam int SlotW      = $clog2(StoredRows);
    localparam int PixW       = 24;
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int HeldW      = DimW + 1;

    // Configuration register indexes
    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgLevels = 2'd2;
    localparam logic [1:0] CfgThresh = 2'd3;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [DimW-1:0] width;
        logic [DimW-1:0] height;
        logic [7:0]      levels;
        logic [7:0]      thresh;
    } t_cfg;

    // Work command from front to back
    typedef struct packed {
        logic              emit;
        logic              has_px;
        logic              wr;
        logic [SlotW-1:0]  wr_slot;
        logic [ColW-1:0]   wr_col;
        logic [PixW-1:0]   px;
    } t_cmd;

    // Floor of x/10 for x below 2560, by reciprocal multiply
    function automatic logic [7:0] div10(input logic [11:0] x);
        logic [25:0] p;
        p = {14'd0, x} * 26'd6554;
        return p[23:16];
    endfunction

endpackage

@@ src/cef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module cef_ram #(
    parameter int Width = 24,
    parameter int Depth = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/cef_queue.sv @@
// Short command queue between the front and back parts.
// Depends on cef_pkg for the command type and depth.
module cef_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cef_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output cef_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    cef_pkg::t_cmd r_slots [cef_pkg::QueueDepth];
    logic [cef_pkg::QPtrW-1:0] r_wptr, r_rptr;
    logic [cef_pkg::QPtrW:0]   r_count;

    assign o_full  = (r_count == (cef_pkg::QPtrW+1)'(cef_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slots[r_rptr];

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/cef_front.sv @@
// Front part: accepts items, tracks pipeline occupancy and input position,
// and turns pixels, and flushes while held, into commands. Depends on cef_pkg.
module cef_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cef_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    input  logic [cef_pkg::PixW-1:0]  i_px,
    input  logic                      i_full,
    output logic                      o_push,
    output cef_pkg::t_cmd             o_cmd
);

    logic [cef_pkg::HeldW-1:0] r_held, n_held, held_inc, lag;
    logic [cef_pkg::ColW-1:0]  r_in_col;
    logic [cef_pkg::DimW-1:0]  r_in_row;
    logic [cef_pkg::SlotW-1:0] r_in_slot;
    logic                      accept, emit_px;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign lag      = {i_cfg.width, 1'b0} + cef_pkg::HeldW'(2);
    assign held_inc = r_held + 1'b1;
    assign emit_px  = (held_inc > lag);

    // Classify the item
    always_comb begin
        o_cmd.emit    = 1'b1;
        o_cmd.has_px  = !i_mode;
        o_cmd.wr      = !i_mode;
        o_cmd.wr_slot = r_in_slot;
        o_cmd.wr_col  = r_in_col;
        o_cmd.px      = i_px;
        o_push        = 1'b0;
        n_held        = r_held;
        if (accept) begin
            if (!i_mode) begin
                o_push     = 1'b1;
                o_cmd.emit = emit_px;
                n_held     = emit_px ? r_held : held_inc;
            end else if (r_held != '0) begin
                o_push = 1'b1;
                n_held = r_held - 1'b1;
            end
        end
    end

    // Advance occupancy and input position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
        end else begin
            r_held <= n_held;
            if (accept && !i_mode) begin
                if ({1'b0, r_in_col} + 12'd1 >= i_cfg.width) begin
                    r_in_col  <= '0;
                    r_in_slot <= r_in_slot + 1'b1;
                    if (r_in_row + 12'd1 >= i_cfg.height) begin
                        r_in_row <= '0;
                    end else begin
                        r_in_row <= r_in_row + 12'd1;
                    end
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
        end
    end

endmodule

@@ src/cef_back.sv @@
// Back part: line store, 5x5 window, blur, gradient, quantize and output register.
// Depends on cef_pkg and cef_ram.
module cef_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cef_pkg::t_cfg i_cfg,
    input  cef_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_blue,
    output logic [7:0]    o_green,
    output logic [7:0]    o_red,
    output logic          o_frame_end
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_BLUR, S_VSUM, S_DIVB, S_DIVQ, S_MULT, S_DONE
    } t_state;

    t_state r_state;
    cef_pkg::t_cmd r_cmd;
    logic [cef_pkg::PixW-1:0]  r_win [5][5];
    logic [cef_pkg::ColW-1:0]  r_out_col;
    logic [cef_pkg::DimW-1:0]  r_out_row;
    logic [cef_pkg::SlotW-1:0] r_out_slot, r_base;
    logic [7:0] r_t [3][5];
    logic signed [8:0]  r_gx [3];
    logic signed [10:0] r_gy [3];
    logic [7:0] r_dnum [3];
    logic [7:0] r_drem [3];
    logic       r_edge [3];
    logic [7:0] r_q [3];
    logic [7:0] r_bnum, r_brem;
    logic [2:0] r_step;
    logic       r_interior, r_ring;

    // Line store
    logic [cef_pkg::PixW-1:0] rd [cef_pkg::StoredRows];
    logic [cef_pkg::ColW-1:0] rd_addr, wr_col;
    logic [cef_pkg::SlotW-1:0] wr_slot, base;
    logic [cef_pkg::PixW-1:0] wr_px;
    logic wr_en, out_free, off;
    logic [11:0] lc_full, lc;

    // Read column and row offset for the next window column
    assign lc_full = {1'b0, r_out_col} + 12'd2;
    assign off     = (lc_full >= i_cfg.width);
    assign lc      = off ? lc_full - i_cfg.width : lc_full;
    assign rd_addr = lc[cef_pkg::ColW-1:0];
    assign base    = r_out_slot + cef_pkg::SlotW'(off) + cef_pkg::SlotW'(2);
    assign out_free = !o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // Select the store write
    always_comb begin
        wr_en   = 1'b0;
        wr_slot = i_cmd.wr_slot;
        wr_col  = i_cmd.wr_col;
        wr_px   = i_cmd.px;
        if (r_state == S_IDLE && !i_empty && !i_cmd.emit && i_cmd.wr) begin
            wr_en = 1'b1;
        end else if (r_state == S_DONE && out_free && r_cmd.wr) begin
            wr_en   = 1'b1;
            wr_slot = r_cmd.wr_slot;
            wr_col  = r_cmd.wr_col;
            wr_px   = r_cmd.px;
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < cef_pkg::StoredRows; gk++) begin : g_rows
            cef_ram #(.Width(cef_pkg::PixW), .Depth(cef_pkg::MaxWidth)) u_row (
                .i_clk   (i_clk),
                .i_we    (wr_en && (wr_slot == cef_pkg::SlotW'(gk))),
                .i_waddr (wr_col),
                .i_wdata (wr_px),
                .i_raddr (rd_addr),
                .o_rdata (rd[gk])
            );
        end
    endgenerate

    // Horizontal blur rows and gradients from the window
    logic [7:0]         n_t [3][5];
    logic signed [8:0]  n_gx [3];
    logic signed [10:0] n_gy [3];
    always_comb begin
        logic [11:0] hs;
        logic [12:0] rr;
        logic [9:0]  s1, s3;
        logic signed [10:0] d1, d2, d3;
        for (int ch = 0; ch < 3; ch++) begin
            for (int dy = 0; dy < 5; dy++) begin
                hs = {4'd0, r_win[dy][0][8*ch +: 8]} + {3'd0, r_win[dy][1][8*ch +: 8], 1'b0}
                   + {2'd0, r_win[dy][2][8*ch +: 8], 2'b0}
                   + {3'd0, r_win[dy][3][8*ch +: 8], 1'b0} + {4'd0, r_win[dy][4][8*ch +: 8]};
                rr = {1'b0, r_out_row} + 13'(dy);
                if (rr >= 13'd4 && rr + 13'd1 <= {1'b0, i_cfg.height}) begin
                    n_t[ch][dy] = cef_pkg::div10(hs);
                end else begin
                    n_t[ch][dy] = r_win[dy][2][8*ch +: 8];
                end
            end
            s1 = {2'd0, r_win[1][1][8*ch +: 8]} + {1'b0, r_win[2][1][8*ch +: 8], 1'b0}
               + {2'd0, r_win[3][1][8*ch +: 8]};
            s3 = {2'd0, r_win[1][3][8*ch +: 8]} + {1'b0, r_win[2][3][8*ch +: 8], 1'b0}
               + {2'd0, r_win[3][3][8*ch +: 8]};
            n_gx[ch] = $signed({1'b0, s3[9:2]}) - $signed({1'b0, s1[9:2]});
            d1 = $signed({3'd0, r_win[1][1][8*ch +: 8]}) - $signed({3'd0, r_win[3][1][8*ch +: 8]});
            d2 = $signed({3'd0, r_win[1][2][8*ch +: 8]}) - $signed({3'd0, r_win[3][2][8*ch +: 8]});
            d3 = $signed({3'd0, r_win[1][3][8*ch +: 8]}) - $signed({3'd0, r_win[3][3][8*ch +: 8]});
            n_gy[ch] = d1 + (d2 <<< 1) + d3;
        end
    end

    // Vertical blur and edge decision
    logic [7:0] n_v [3];
    logic       n_edge [3];
    logic [16:0] thr_sq;
    assign thr_sq = ({9'd0, i_cfg.thresh} + 17'd1) * ({9'd0, i_cfg.thresh} + 17'd1);
    always_comb begin
        logic [11:0] vs;
        logic [20:0] mag2;
        for (int ch = 0; ch < 3; ch++) begin
            vs = {4'd0, r_t[ch][0]} + {3'd0, r_t[ch][1], 1'b0} + {2'd0, r_t[ch][2], 2'b0}
               + {3'd0, r_t[ch][3], 1'b0} + {4'd0, r_t[ch][4]};
            n_v[ch] = r_interior ? cef_pkg::div10(vs) : r_win[2][2][8*ch +: 8];
            mag2 = 21'(r_gx[ch] * r_gx[ch]) + 21'(r_gy[ch] * r_gy[ch]);
            n_edge[ch] = r_ring && (i_cfg.thresh != 8'd255) && (mag2 >= {4'd0, thr_sq});
        end
    end

    // Sequence one item through the back part
    always_ff @(posedge i_clk) begin
        logic [8:0] rs;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            o_valid     <= 1'b0;
            o_frame_end <= 1'b0;
            for (int y = 0; y < 5; y++) begin
                for (int x = 0; x < 5; x++) begin
                    r_win[y][x] <= '0;
                end
            end
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty && i_cmd.emit) begin
                        r_cmd      <= i_cmd;
                        r_base     <= base;
                        r_interior <= ({1'b0, r_out_row} >= 13'd2)
                                   && ({1'b0, r_out_row} + 13'd3 <= {1'b0, i_cfg.height})
                                   && (r_out_col >= 11'd2)
                                   && ({2'd0, r_out_col} + 13'd3 <= {1'b0, i_cfg.width});
                        r_ring     <= (r_out_row != '0)
                                   && ({1'b0, r_out_row} + 13'd2 <= {1'b0, i_cfg.height})
                                   && (r_out_col != '0)
                                   && ({2'd0, r_out_col} + 13'd2 <= {1'b0, i_cfg.width});
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int y = 0; y < 5; y++) begin
                        for (int x = 0; x < 4; x++) begin
                            r_win[y][x] <= r_win[y][x+1];
                        end
                    end
                    for (int y = 0; y < 4; y++) begin
                        r_win[y][4] <= rd[r_base + cef_pkg::SlotW'(y)];
                    end
                    r_win[4][4] <= r_cmd.has_px ? r_cmd.px : rd[r_base];
                    r_state <= S_BLUR;
                end
                S_BLUR: begin
                    r_t     <= n_t;
                    r_gx    <= n_gx;
                    r_gy    <= n_gy;
                    r_state <= S_VSUM;
                end
                S_VSUM: begin
                    r_dnum  <= n_v;
                    r_edge  <= n_edge;
                    r_bnum  <= 8'd255;
                    r_brem  <= '0;
                    r_step  <= '0;
                    r_state <= S_DIVB;
                end
                S_DIVB: begin
                    // bucket = 255 / levels, one quotient bit a step
                    rs = {r_brem, r_bnum[7]};
                    if (rs >= {1'b0, i_cfg.levels}) begin
                        r_brem <= 8'(rs - {1'b0, i_cfg.levels});
                        r_bnum <= {r_bnum[6:0], 1'b1};
                    end else begin
                        r_brem <= rs[7:0];
                        r_bnum <= {r_bnum[6:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd7) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            r_drem[ch] <= '0;
                        end
                        r_state <= S_DIVQ;
                    end
                end
                S_DIVQ: begin
                    // value / bucket per channel
                    for (int ch = 0; ch < 3; ch++) begin
                        rs = {r_drem[ch], r_dnum[ch][7]};
                        if (rs >= {1'b0, r_bnum}) begin
                            r_drem[ch] <= 8'(rs - {1'b0, r_bnum});
                            r_dnum[ch] <= {r_dnum[ch][6:0], 1'b1};
                        end else begin
                            r_drem[ch] <= rs[7:0];
                            r_dnum[ch] <= {r_dnum[ch][6:0], 1'b0};
                        end
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd7) begin
                        r_state <= S_MULT;
                    end
                end
                S_MULT: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_q[ch] <= 8'({8'd0, r_dnum[ch]} * {8'd0, r_bnum});
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid     <= 1'b1;
                        o_blue      <= r_edge[0] ? 8'd0 : r_q[0];
                        o_green     <= r_edge[1] ? 8'd0 : r_q[1];
                        o_red       <= r_edge[2] ? 8'd0 : r_q[2];
                        o_frame_end <= ({1'b0, r_out_col} + 12'd1 >= i_cfg.width)
                                    && (r_out_row + 12'd1 >= i_cfg.height);
                        if ({1'b0, r_out_col} + 12'd1 >= i_cfg.width) begin
                            r_out_col  <= '0;
                            r_out_slot <= r_out_slot + 1'b1;
                            if (r_out_row + 12'd1 >= i_cfg.height) begin
                                r_out_row <= '0;
                            end else begin
                                r_out_row <= r_out_row + 12'd1;
                            end
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/cartoon_edge_quantize_filter.sv @@
// Cartoon filter: blur, quantize and edge blanking of a BGR pixel stream.
// Input items enter a 4-deep command queue at one per cycle while it has room.
// A pixel with no result only writes the line store; an item with a result goes
// through window load, blur, two 8-step serial dividers, one item at a time.
// Results trail the input by 2*W+2 pixel items. Synchronous active-low reset
// restores register defaults and clears the window; the line store is not cleared.
module cartoon_edge_quantize_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_red_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_red_out,
    output logic        o_frame_end
);

    logic [11:0] r_width, r_height;
    logic [7:0]  r_levels, r_thresh;
    cef_pkg::t_cfg cfg;
    cef_pkg::t_cmd push_cmd, head_cmd;
    logic push, full, pop, empty;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_levels <= 8'd8;
            r_thresh <= 8'd15;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cef_pkg::CfgWidth:  r_width  <= i_cfg_data;
                cef_pkg::CfgHeight: r_height <= i_cfg_data;
                cef_pkg::CfgLevels: r_levels <= i_cfg_data[7:0];
                cef_pkg::CfgThresh: r_thresh <= i_cfg_data[7:0];
                default: r_thresh <= r_thresh;
            endcase
        end
    end

    // Clamp to the supported ranges
    always_comb begin
        cfg.width  = (r_width < 12'd5) ? 12'd5 :
                     (r_width > 12'(cef_pkg::MaxWidth)) ? 12'(cef_pkg::MaxWidth) : r_width;
        cfg.height = (r_height < 12'd5) ? 12'd5 : r_height;
        cfg.levels = (r_levels == 8'd0) ? 8'd1 : r_levels;
        cfg.thresh = r_thresh;
    end

    cef_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_px    ({i_red_in, i_green_in, i_blue_in}),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    cef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    cef_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_blue      (o_blue_out),
        .o_green     (o_green_out),
        .o_red       (o_red_out),
        .o_frame_end (o_frame_end)
    );

endmodule

@@ bench/cartoon_edge_quantize_filter_test.sv @@
// Self-checking testbench for the cartoon edge/quantize filter: drives directed and random
// pixel/flush items and checks every result against a bit-exact predictor. Depends on cef_pkg.
module cartoon_edge_quantize_filter_test;

    localparam int IdleLimit = 20000;
    localparam int SettleCycles = 100;
    localparam int RandomPixels = 1850;
    localparam int MaxTestWidth = 12;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } t_cartoon_px;

    typedef struct {
        logic       mode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        bit         no_result;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = cef_pkg::CfgWidth;
    logic [11:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [7:0]  i_blue_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_red_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_red_out;
    logic        o_frame_end;

    cartoon_edge_quantize_filter u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [23:0] line_mem [0:cef_pkg::StoredRows*cef_pkg::MaxWidth-1];
    logic [23:0] win [0:24];
    int unsigned in_row, in_col, out_row, out_col, in_slot, out_slot, pending;
    int unsigned cfg_w, cfg_h, cfg_lv, cfg_th;

    t_cartoon_px expected_px[$];
    int          fail_count = 0;
    int          idle_count = 0;
    bit          no_idle = 1'b0;

    function automatic int unsigned eff_w();
        return cfg_w < 5 ? 5 : (cfg_w > cef_pkg::MaxWidth ? cef_pkg::MaxWidth : cfg_w);
    endfunction

    function automatic int unsigned eff_h();
        return cfg_h < 5 ? 5 : cfg_h;
    endfunction

    function automatic int wpix(int y, int x, int ch);
        return int'(win[y*5+x][8*ch +: 8]);
    endfunction

    function automatic int unsigned int_sqrt(int unsigned n);
        int unsigned r, b;
        r = 0;
        b = 32'h4000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Blur, quantize and blank one channel of the window center
    function automatic logic [7:0] cartoon_channel(int r, int c, int h, int w, int ch);
        int v, dy, row, s1, s3, gx, gy;
        int t [5];
        int unsigned bucket, q, m;
        bucket = 255 / (cfg_lv == 0 ? 1 : cfg_lv);
        m = 0;
        if (r >= 2 && r <= h - 3 && c >= 2 && c <= w - 3) begin
            for (dy = 0; dy < 5; dy++) begin
                row = r - 2 + dy;
                if (row >= 2 && row <= h - 3)
                    t[dy] = (wpix(dy, 0, ch) + 2 * wpix(dy, 1, ch) + 4 * wpix(dy, 2, ch)
                             + 2 * wpix(dy, 3, ch) + wpix(dy, 4, ch)) / 10;
                else
                    t[dy] = wpix(dy, 2, ch);
            end
            v = (t[0] + 2 * t[1] + 4 * t[2] + 2 * t[3] + t[4]) / 10;
        end else begin
            v = wpix(2, 2, ch);
        end
        q = (v / bucket) * bucket;
        if (r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2) begin
            s1 = (wpix(1, 1, ch) + 2 * wpix(2, 1, ch) + wpix(3, 1, ch)) / 4;
            s3 = (wpix(1, 3, ch) + 2 * wpix(2, 3, ch) + wpix(3, 3, ch)) / 4;
            gx = s3 - s1;
            gy = (wpix(1, 1, ch) - wpix(3, 1, ch)) + 2 * (wpix(1, 2, ch) - wpix(3, 2, ch))
                 + (wpix(1, 3, ch) - wpix(3, 3, ch));
            m = int_sqrt(gx * gx + gy * gy);
            if (m > 255) m = 255;
        end
        return m > cfg_th ? 8'd0 : q[7:0];
    endfunction

    function automatic logic [23:0] line_read(int unsigned slot, int unsigned col);
        return line_mem[(slot % cef_pkg::StoredRows) * cef_pkg::MaxWidth + col];
    endfunction

    // Shift the window by one column and produce the next output pixel
    function automatic t_cartoon_px advance_output(bit has_px, logic [23:0] px);
        int unsigned w, h, lc, off;
        t_cartoon_px res;
        w = eff_w();
        h = eff_h();
        if (out_col + 2 < w) begin
            lc = out_col + 2;
            off = 0;
        end else begin
            lc = out_col + 2 - w;
            off = 1;
        end
        for (int y = 0; y < 5; y++)
            for (int x = 0; x < 4; x++)
                win[y*5+x] = win[y*5+x+1];
        for (int y = 0; y < 4; y++)
            win[y*5+4] = line_read(out_slot + off + y + 2, lc);
        win[24] = has_px ? px : line_read(out_slot + off + 2, lc);
        res.blue  = cartoon_channel(out_row, out_col, h, w, 0);
        res.green = cartoon_channel(out_row, out_col, h, w, 1);
        res.red   = cartoon_channel(out_row, out_col, h, w, 2);
        res.frame_end = 1'b0;
        if (out_col + 1 >= w) begin
            out_col = 0;
            out_slot = (out_slot + 1) % cef_pkg::StoredRows;
            if (out_row + 1 >= h) begin
                out_row = 0;
                res.frame_end = 1'b1;
            end else begin
                out_row++;
            end
        end else begin
            out_col++;
        end
        return res;
    endfunction

    // Apply one accepted item; return 1 with the expected pixel if it makes one
    function automatic bit cartoon_predict(logic mode, logic [23:0] px, output t_cartoon_px res);
        int unsigned w;
        bit made;
        w = eff_w();
        made = 1'b0;
        res = '0;
        if (mode == 1'b0) begin
            pending++;
            if (pending > 2 * w + 2) begin
                res = advance_output(1'b1, px);
                pending--;
                made = 1'b1;
            end
            line_mem[(in_slot % cef_pkg::StoredRows) * cef_pkg::MaxWidth + in_col] = px;
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_slot = (in_slot + 1) % cef_pkg::StoredRows;
                in_row = (in_row + 1 >= eff_h()) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
        end else if (pending > 0) begin
            res = advance_output(1'b0, '0);
            pending--;
            made = 1'b1;
        end
        return made;
    endfunction

    // Send one item and predict it once accepted; typed rows expect no result
    task automatic send_item(logic mode, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             bit typed_none = 1'b0);
        t_cartoon_px res;
        if (!no_idle && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_blue_in <= b;
        i_green_in <= g;
        i_red_in <= r;
        do @(posedge i_clk); while (!o_ready);
        if (cartoon_predict(mode, {r, g, b}, res) && !typed_none)
            expected_px.push_back(res);
    endtask

    // Write all four registers while the block is idle
    task automatic write_config(int unsigned w, int unsigned h, int unsigned lv, int unsigned th);
        i_valid <= 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= cef_pkg::CfgWidth;  i_cfg_data <= w[11:0];  @(posedge i_clk);
        i_cfg_idx <= cef_pkg::CfgHeight; i_cfg_data <= h[11:0];  @(posedge i_clk);
        i_cfg_idx <= cef_pkg::CfgLevels; i_cfg_data <= lv[11:0]; @(posedge i_clk);
        i_cfg_idx <= cef_pkg::CfgThresh; i_cfg_data <= th[11:0]; @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_w = w & 12'hFFF;
        cfg_h = h & 12'hFFF;
        cfg_lv = lv & 8'hFF;
        cfg_th = th & 8'hFF;
    endtask

    // Flush out pending pixels and let the block settle
    task automatic drain();
        while (pending > 0)
            send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        i_valid <= 1'b0;
        while (expected_px.size() > 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Result checker with random back-pressure
    always @(posedge i_clk) begin
        t_cartoon_px exp_px;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected result b=%0d g=%0d r=%0d fe=%0d", $time,
                         o_blue_out, o_green_out, o_red_out, o_frame_end);
                fail_count++;
            end else begin
                exp_px = expected_px.pop_front();
                if (o_blue_out !== exp_px.blue || o_green_out !== exp_px.green ||
                    o_red_out !== exp_px.red || o_frame_end !== exp_px.frame_end) begin
                    $display("%0t: mismatch expected b=%0d g=%0d r=%0d fe=%0d, got b=%0d g=%0d r=%0d fe=%0d",
                             $time, exp_px.blue, exp_px.green, exp_px.red, exp_px.frame_end,
                             o_blue_out, o_green_out, o_red_out, o_frame_end);
                    fail_count++;
                end
            end
        end
        i_ready <= no_idle || ($urandom_range(99) >= 18);
    end

    // Watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    t_stim_row directed [] = '{
        '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
        '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1}, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1},
        '{1'b0, 8'h80, 8'h01, 8'hFE, 1'b1}, '{1'b0, 8'h55, 8'hAA, 8'h7F, 1'b1},
        '{1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1}, '{1'b0, 8'h10, 8'h20, 8'h30, 1'b1},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1}, '{1'b0, 8'h00, 8'hFF, 8'h00, 1'b1},
        '{1'b0, 8'h01, 8'h02, 8'h04, 1'b1}, '{1'b0, 8'h08, 8'h10, 8'h20, 1'b1},
        '{1'b0, 8'h40, 8'h80, 8'hFF, 1'b1}, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0}, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{1'b0, 8'hC8, 8'hC8, 8'hC8, 1'b0}, '{1'b0, 8'hC9, 8'hC8, 8'hC7, 1'b0},
        '{1'b0, 8'hFF, 8'h00, 8'h80, 1'b0}, '{1'b0, 8'h7F, 8'h80, 8'h81, 1'b0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0}, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        '{1'b0, 8'hAA, 8'h55, 8'hAA, 1'b0}, '{1'b0, 8'h55, 8'hAA, 8'h55, 1'b0},
        '{1'b0, 8'hFE, 8'hFD, 8'hFC, 1'b0}, '{1'b0, 8'h03, 8'h02, 8'h01, 1'b0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0}
    };

    initial begin
        int unsigned sent, w, h, base, span, n_frames, cut;
        logic [7:0] b, g, r;
        for (int k = 0; k < cef_pkg::StoredRows * cef_pkg::MaxWidth; k++) line_mem[k] = '0;
        for (int k = 0; k < 25; k++) win[k] = '0;
        {in_row, in_col, out_row, out_col, in_slot, out_slot, pending} = '0;
        cfg_w = 640; cfg_h = 480; cfg_lv = 8; cfg_th = 15;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every line-store entry that the test frames can reach
        no_idle = 1'b1;
        write_config(MaxTestWidth, 0, 255, 255);
        for (int k = 0; k < MaxTestWidth * 5; k++)
            send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        drain();
        no_idle = 1'b0;

        // Directed 5x5 frame at the low extremes of every register
        write_config(0, 5, 0, 0);
        foreach (directed[k])
            send_item(directed[k].mode, directed[k].blue, directed[k].green,
                      directed[k].red, directed[k].no_result);
        drain();

        // Random phases of frames with random settings
        sent = 0;
        for (int phase = 0; sent < RandomPixels; phase++) begin
            no_idle = (phase % 4 == 3);
            w = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, MaxTestWidth);
            h = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 8);
            if (phase == 2) h = 4095;
            write_config(w, h, (phase % 5 == 0) ? 255 : $urandom_range(255),
                         (phase % 3 == 0) ? 255 : $urandom_range(60));
            n_frames = (h == 4095) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                base = $urandom;
                span = ($urandom_range(2) == 0) ? 256 : $urandom_range(1, 24);
                cut = ($urandom_range(9) == 0) ? $urandom_range(1, eff_w() * eff_h() - 1) : 0;
                for (int k = 0; k < ((h == 4095) ? 30 * eff_w() : eff_w() * eff_h()); k++) begin
                    b = base[7:0] + 8'($urandom_range(span - 1));
                    g = base[15:8] + 8'($urandom_range(span - 1));
                    r = base[23:16] + 8'($urandom_range(span - 1));
                    send_item(1'b0, b, g, r);
                    sent++;
                    // Early flush in the middle of a frame
                    if (cut != 0 && k == cut)
                        repeat ($urandom_range(1, 6))
                            send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
                end
                repeat ($urandom_range(3))
                    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            drain();
        end
        no_idle = 1'b0;

        if (fail_count == 0 && expected_px.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (expected_px.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, expected_px.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/cef_pkg.sv
src/cef_ram.sv
src/cef_queue.sv
src/cef_front.sv
src/cef_back.sv
src/cartoon_edge_quantize_filter.sv
bench/cartoon_edge_quantize_filter_test.sv
